// ----- rtl/word_frequency_table_defines.svh -----
// Assertion macros for the word frequency table checker.
`ifndef WORD_FREQUENCY_TABLE_DEFINES_SVH
`define WORD_FREQUENCY_TABLE_DEFINES_SVH

`define WFT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define WFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/wft_pkg.sv -----
// Shared types and constants of the word frequency table.
package wft_pkg;

  localparam int unsigned Capacity   = 256;
  localparam int unsigned MaxLetters = 24;
  localparam int unsigned WordW      = 120;
  localparam int unsigned CountW     = 32;

  localparam logic [1:0] KindAdd    = 2'd0;
  localparam logic [1:0] KindRemove = 2'd1;
  localparam logic [1:0] KindRead   = 2'd2;
  localparam logic [1:0] KindSort   = 2'd3;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusFull  = 2'd1;
  localparam logic [1:0] StatusRange = 2'd2;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [7:0]  position;
    logic [31:0] occurrences;
    logic [59:0] out_head;
    logic [59:0] out_tail;
    logic [8:0]  entries;
  } result_t;

  // Clear letters past the limit and after the first zero code.
  function automatic logic [WordW-1:0] normalize(input logic [WordW-1:0] w,
                                                 input int unsigned max_letters);
    logic [WordW-1:0] r;
    logic dead;
    r = w;
    dead = 1'b0;
    for (int i = 0; i < 24; i++) begin
      if (i >= max_letters) dead = 1'b1;
      if (r[WordW-1-5*i -: 5] == 5'd0) dead = 1'b1;
      if (dead) r[WordW-1-5*i -: 5] = 5'd0;
    end
    return r;
  endfunction

endpackage

// ----- rtl/wft_store.sv -----
// Word and count memories, one synchronous read port and one write port.
module wft_store #(
  parameter int unsigned CAPACITY = wft_pkg::Capacity,
  parameter int unsigned AW = $clog2(CAPACITY)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [wft_pkg::WordW-1:0]  wword_i,
  input  logic [wft_pkg::CountW-1:0] wcount_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [wft_pkg::WordW-1:0]  rword_o,
  output logic [wft_pkg::CountW-1:0] rcount_o
);

  logic [wft_pkg::WordW-1:0]  word_mem  [CAPACITY];
  logic [wft_pkg::CountW-1:0] count_mem [CAPACITY];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      word_mem[waddr_i]  <= wword_i;
      count_mem[waddr_i] <= wcount_i;
    end
    rword_o  <= word_mem[raddr_i];
    rcount_o <= count_mem[raddr_i];
  end

endmodule

// ----- rtl/wft_ctrl.sv -----
// Sequencer: scan, update, shift, read and sort over the table memory.
module wft_ctrl #(
  parameter int unsigned CAPACITY = wft_pkg::Capacity,
  parameter int unsigned MAX_LETTERS = wft_pkg::MaxLetters,
  parameter int unsigned AW = $clog2(CAPACITY)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 kind_i,
  input  logic [wft_pkg::WordW-1:0]  word_i,
  input  logic [7:0]                 index_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output wft_pkg::result_t           res_o,
  output logic                       we_o,
  output logic [AW-1:0]              waddr_o,
  output logic [wft_pkg::WordW-1:0]  wword_o,
  output logic [wft_pkg::CountW-1:0] wcount_o,
  output logic [AW-1:0]              raddr_o,
  input  logic [wft_pkg::WordW-1:0]  rword_i,
  input  logic [wft_pkg::CountW-1:0] rcount_i
);

  typedef enum logic [9:0] {
    StIdle   = 10'b0000000001,
    StScan   = 10'b0000000010,
    StScanW  = 10'b0000000100,
    StShift  = 10'b0000001000,
    StShiftW = 10'b0000010000,
    StRead   = 10'b0000100000,
    StSortI  = 10'b0001000000,
    StSortJ  = 10'b0010000000,
    StSortW  = 10'b0100000000,
    StDone   = 10'b1000000000
  } state_e;

  localparam int unsigned TW = AW + 1;
  localparam logic [TW-1:0] CapT = TW'(CAPACITY);

  state_e state_q, state_d;
  logic [TW-1:0] total_q, total_d;
  logic [TW-1:0] ptr_q, ptr_d;
  logic [TW-1:0] ins_q, ins_d;
  logic [1:0] kind_q, kind_d;
  logic [wft_pkg::WordW-1:0] key_q, key_d;
  logic [wft_pkg::CountW-1:0] kcnt_q, kcnt_d;
  logic [7:0] idx_q, idx_d;
  wft_pkg::result_t res_q, res_d;
  logic out_v_q, out_v_d;

  assign in_ready_o = (state_q == StIdle) && !out_v_q;
  assign res_valid_o = out_v_q;
  assign res_o = res_q;

  always_comb begin
    state_d = state_q;
    total_d = total_q;
    ptr_d = ptr_q;
    ins_d = ins_q;
    kind_d = kind_q;
    key_d = key_q;
    kcnt_d = kcnt_q;
    idx_d = idx_q;
    res_d = res_q;
    out_v_d = out_v_q;
    we_o = 1'b0;
    waddr_o = ptr_q[AW-1:0];
    wword_o = key_q;
    wcount_o = kcnt_q;
    raddr_o = ptr_q[AW-1:0];
    if (out_v_q && res_ready_i) out_v_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          kind_d = kind_i;
          key_d = wft_pkg::normalize(word_i, MAX_LETTERS);
          idx_d = index_i;
          ptr_d = '0;
          res_d = '0;
          raddr_o = '0;
          case (kind_i)
            wft_pkg::KindAdd, wft_pkg::KindRemove: state_d = StScan;
            wft_pkg::KindRead: begin
              raddr_o = AW'(index_i);
              state_d = StRead;
            end
            default: begin
              ptr_d = TW'(1);
              state_d = StSortI;
            end
          endcase
        end
      end
      StScan: begin
        if (ptr_q >= total_q) begin
          if (kind_q == wft_pkg::KindAdd) begin
            if (total_q < CapT) begin
              we_o = 1'b1;
              waddr_o = total_q[AW-1:0];
              wcount_o = 32'd1;
              res_d.position = 8'(total_q);
              res_d.occurrences = 32'd1;
              total_d = total_q + TW'(1);
            end else begin
              res_d.status = wft_pkg::StatusFull;
            end
          end
          state_d = StDone;
        end else begin
          state_d = StScanW;
        end
      end
      StScanW: begin
        if (rword_i == key_q) begin
          res_d.found = 1'b1;
          res_d.position = 8'(ptr_q);
          if (kind_q == wft_pkg::KindAdd) begin
            we_o = 1'b1;
            wword_o = rword_i;
            wcount_o = (rcount_i == '1) ? rcount_i : rcount_i + 32'd1;
            res_d.occurrences = wcount_o;
            state_d = StDone;
          end else begin
            ptr_d = ptr_q + TW'(1);
            raddr_o = AW'(ptr_q + TW'(1));
            state_d = StShift;
          end
        end else begin
          ptr_d = ptr_q + TW'(1);
          raddr_o = AW'(ptr_q + TW'(1));
          state_d = StScan;
        end
      end
      StShift: begin
        if (ptr_q >= total_q) begin
          total_d = total_q - TW'(1);
          state_d = StDone;
        end else begin
          state_d = StShiftW;
        end
      end
      StShiftW: begin
        we_o = 1'b1;
        waddr_o = AW'(ptr_q - TW'(1));
        wword_o = rword_i;
        wcount_o = rcount_i;
        ptr_d = ptr_q + TW'(1);
        raddr_o = AW'(ptr_q + TW'(1));
        state_d = StShift;
      end
      StRead: begin
        if (32'(idx_q) < 32'(total_q)) begin
          res_d.position = idx_q;
          res_d.occurrences = rcount_i;
          res_d.out_head = rword_i[119:60];
          res_d.out_tail = rword_i[59:0];
        end else begin
          res_d.status = wft_pkg::StatusRange;
        end
        state_d = StDone;
      end
      StSortI: begin
        // ptr is i; load key from entry i.
        if (ptr_q >= total_q) begin
          state_d = StDone;
        end else if (ins_q == TW'(0) && kind_q == wft_pkg::KindSort) begin
          ins_d = TW'(CAPACITY + 1);
          raddr_o = ptr_q[AW-1:0];
        end else if (ins_q == TW'(CAPACITY + 1)) begin
          ins_d = ptr_q;
          key_d = rword_i;
          kcnt_d = rcount_i;
          raddr_o = AW'(ptr_q - TW'(1));
          state_d = StSortJ;
        end
      end
      StSortJ: begin
        // ins is j; entry j-1 is on the read port.
        if (ins_q != TW'(0) && rword_i > key_q) begin
          we_o = 1'b1;
          waddr_o = ins_q[AW-1:0];
          wword_o = rword_i;
          wcount_o = rcount_i;
          ins_d = ins_q - TW'(1);
          raddr_o = AW'(ins_q - TW'(2));
          state_d = StSortW;
        end else begin
          we_o = 1'b1;
          waddr_o = ins_q[AW-1:0];
          ins_d = '0;
          ptr_d = ptr_q + TW'(1);
          state_d = StSortI;
        end
      end
      StSortW: begin
        raddr_o = AW'(ins_q - TW'(1));
        state_d = StSortJ;
      end
      StDone: begin
        res_d.entries = 9'(total_q);
        ins_d = '0;
        out_v_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      total_q <= '0;
      out_v_q <= 1'b0;
      ins_q <= '0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      out_v_q <= out_v_d;
      ins_q <= ins_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    kind_q <= kind_d;
    key_q <= key_d;
    kcnt_q <= kcnt_d;
    idx_q <= idx_d;
    res_q <= res_d;
  end

endmodule

// ----- rtl/word_frequency_table.sv -----
// Top level of the word frequency table.
// Input beats carry one operation each: add, remove, read or sort a table of
// up to CAPACITY words with saturating 32-bit counts. Each input beat yields
// exactly one output beat with status, found flag, position, count, the word
// read and the number of entries held.
// Add and remove scan the stored entries through one synchronous memory
// read port. A remove shifts the entries behind the match down in place of
// scanning them. A sort is an insertion sort over the same port.
// One item is in work at a time; s_axis_tready is high only when idle and
// the output register is empty, so a stalled receiver holds the next beat.
// The next input beat is taken in the cycle after the output beat or later.
// Reset clears the entry count; memory content is undefined until written
// and never read before it is written. No clearing pass is needed.
module word_frequency_table #(
  parameter int unsigned CAPACITY = wft_pkg::Capacity,
  parameter int unsigned MAX_LETTERS = wft_pkg::MaxLetters
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // kind[1:0], word_head[61:2], word_tail[121:62], entry_index[129:122], pad
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0], found[2], position[10:3], occurrences[42:11],
  // out_head[102:43], out_tail[162:103], entries[171:163], pad
  output logic [175:0] m_axis_tdata
);

  localparam int unsigned AW = $clog2(CAPACITY);

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [wft_pkg::WordW-1:0] wword, rword;
  logic [wft_pkg::CountW-1:0] wcount, rcount;
  wft_pkg::result_t res;

  wft_store #(.CAPACITY(CAPACITY), .AW(AW)) u_store (
    .clk_i, .we_i(we), .waddr_i(waddr), .wword_i(wword), .wcount_i(wcount),
    .raddr_i(raddr), .rword_o(rword), .rcount_o(rcount)
  );

  wft_ctrl #(.CAPACITY(CAPACITY), .MAX_LETTERS(MAX_LETTERS), .AW(AW)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .kind_i(s_axis_tdata[1:0]),
    .word_i({s_axis_tdata[61:2], s_axis_tdata[121:62]}),
    .index_i(s_axis_tdata[129:122]),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res),
    .we_o(we), .waddr_o(waddr), .wword_o(wword), .wcount_o(wcount),
    .raddr_o(raddr), .rword_i(rword), .rcount_i(rcount)
  );

  assign m_axis_tdata = {4'd0, res.entries, res.out_tail, res.out_head,
                         res.occurrences, res.position, res.found, res.status};

endmodule

// ----- rtl/wft_checker.sv -----
// Port-level checker for the word frequency table, bound to the top level.
`include "word_frequency_table_defines.svh"
module wft_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [135:0] s_axis_tdata,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [175:0] m_axis_tdata
);

  `WFT_ASSERT_IMPL(a_no_take_while_out, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready)
  `WFT_ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `WFT_ASSERT_IMPL(a_status_code, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3)
  `WFT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind word_frequency_table wft_checker u_wft_checker (.*);

// ----- tb/tb_word_frequency_table.sv -----
// Testbench for word_frequency_table: directed and random stream traffic against a predictor.
module tb_word_frequency_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LimitCycles = 20_000_000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // kind[1:0], word_head[61:2], word_tail[121:62], entry_index[129:122], pad
  logic [135:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // status[1:0], found[2], position[10:3], occurrences[42:11],
  // out_head[102:43], out_tail[162:103], entries[171:163], pad
  logic [175:0] m_axis_tdata;

  word_frequency_table DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  logic [wft_pkg::WordW-1:0]  tbl_word [wft_pkg::Capacity];
  logic [wft_pkg::CountW-1:0] tbl_count[wft_pkg::Capacity];
  int unsigned                tbl_total;
  wft_pkg::result_t           pending_results[$];
  int unsigned                send_idle_pct;
  int unsigned                recv_idle_pct;
  int unsigned                error_count;
  int unsigned                cycle_count;
  logic [wft_pkg::WordW-1:0]  vocab[48];

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LimitCycles) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [wft_pkg::WordW-1:0] clean_word(
      input logic [wft_pkg::WordW-1:0] w);
    logic dead;
    dead = 1'b0;
    for (int i = 0; i < 24; i++) begin
      if (i >= wft_pkg::MaxLetters) dead = 1'b1;
      if (w[wft_pkg::WordW-1-5*i -: 5] == 5'd0) dead = 1'b1;
      if (dead) w[wft_pkg::WordW-1-5*i -: 5] = 5'd0;
    end
    return w;
  endfunction

  function automatic logic [wft_pkg::WordW-1:0] word_of(input string s);
    logic [wft_pkg::WordW-1:0] w;
    w = '0;
    for (int i = 0; i < s.len() && i < 24; i++)
      w[wft_pkg::WordW-1-5*i -: 5] = 5'(s[i] - 8'd96);
    return w;
  endfunction

  function automatic logic [wft_pkg::WordW-1:0] random_word(input int unsigned n_letters);
    logic [wft_pkg::WordW-1:0] w;
    w = '0;
    for (int i = 0; i < n_letters; i++)
      w[wft_pkg::WordW-1-5*i -: 5] = ($urandom_range(0, 19) == 0) ?
                                     5'($urandom_range(27, 31)) :
                                     5'($urandom_range(1, 26));
    return w;
  endfunction

  function automatic logic [wft_pkg::WordW-1:0] random_bits();
    logic [127:0] b;
    b = {$urandom, $urandom, $urandom, $urandom};
    return b[wft_pkg::WordW-1:0];
  endfunction

  function automatic int find_entry(input logic [wft_pkg::WordW-1:0] w);
    for (int i = 0; i < tbl_total; i++)
      if (tbl_word[i] == w) return i;
    return -1;
  endfunction

  function automatic wft_pkg::result_t apply_item(input logic [1:0] kind,
                                                  input logic [wft_pkg::WordW-1:0] raw,
                                                  input logic [7:0] idx);
    wft_pkg::result_t r;
    logic [wft_pkg::WordW-1:0] w, kw;
    logic [wft_pkg::CountW-1:0] kc;
    int loc, j;
    r = '0;
    w = clean_word(raw);
    case (kind)
      wft_pkg::KindAdd: begin
        loc = find_entry(w);
        if (loc >= 0) begin
          if (tbl_count[loc] != '1) tbl_count[loc]++;
          r.found = 1'b1;
          r.position = 8'(loc);
          r.occurrences = tbl_count[loc];
        end else if (tbl_total < wft_pkg::Capacity) begin
          tbl_word[tbl_total] = w;
          tbl_count[tbl_total] = 1;
          r.position = 8'(tbl_total);
          r.occurrences = 1;
          tbl_total++;
        end else begin
          r.status = wft_pkg::StatusFull;
        end
      end
      wft_pkg::KindRemove: begin
        loc = find_entry(w);
        if (loc >= 0) begin
          for (int i = loc; i + 1 < tbl_total; i++) begin
            tbl_word[i] = tbl_word[i+1];
            tbl_count[i] = tbl_count[i+1];
          end
          tbl_total--;
          r.found = 1'b1;
          r.position = 8'(loc);
        end
      end
      wft_pkg::KindRead: begin
        if (idx < tbl_total) begin
          r.position = idx;
          r.occurrences = tbl_count[idx];
          r.out_head = tbl_word[idx][119:60];
          r.out_tail = tbl_word[idx][59:0];
        end else begin
          r.status = wft_pkg::StatusRange;
        end
      end
      default: begin
        for (int i = 1; i < tbl_total; i++) begin
          kw = tbl_word[i];
          kc = tbl_count[i];
          j = i;
          while (j > 0 && tbl_word[j-1] > kw) begin
            tbl_word[j] = tbl_word[j-1];
            tbl_count[j] = tbl_count[j-1];
            j--;
          end
          tbl_word[j] = kw;
          tbl_count[j] = kc;
        end
      end
    endcase
    r.entries = 9'(tbl_total);
    return r;
  endfunction

  task automatic report(input string field, input logic [63:0] got, input logic [63:0] exp);
    $display("%0t mismatch %s: got %h expected %h", $realtime, field, got, exp);
    error_count++;
  endtask

  task automatic send_item(input logic [1:0] kind, input logic [wft_pkg::WordW-1:0] w,
                           input logic [7:0] idx);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, idx, w[59:0], w[119:60], kind};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(apply_item(kind, w, idx));
  endtask

  always @(posedge clk_i) begin
    wft_pkg::result_t got, exp;
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[1:0], m_axis_tdata[2], m_axis_tdata[10:3], m_axis_tdata[42:11],
               m_axis_tdata[102:43], m_axis_tdata[162:103], m_axis_tdata[171:163]};
        if (pending_results.size() == 0) begin
          report("unexpected beat", 64'(got.entries), 64'd0);
        end else begin
          exp = pending_results.pop_front();
          if (got.status != exp.status)
            report("status", 64'(got.status), 64'(exp.status));
          if (got.found != exp.found)
            report("found", 64'(got.found), 64'(exp.found));
          if (got.position != exp.position)
            report("position", 64'(got.position), 64'(exp.position));
          if (got.occurrences != exp.occurrences)
            report("occurrences", 64'(got.occurrences), 64'(exp.occurrences));
          if (got.out_head != exp.out_head)
            report("out_head", 64'(got.out_head), 64'(exp.out_head));
          if (got.out_tail != exp.out_tail)
            report("out_tail", 64'(got.out_tail), 64'(exp.out_tail));
          if (got.entries != exp.entries)
            report("entries", 64'(got.entries), 64'(exp.entries));
        end
      end
    end
  end

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_item(wft_pkg::KindRead, '0, 8'd0);
    send_item(wft_pkg::KindRemove, word_of("ghost"), 8'd0);
    send_item(wft_pkg::KindAdd, '0, 8'd0);
    send_item(wft_pkg::KindAdd, word_of("abc"), 8'd0);
    send_item(wft_pkg::KindAdd, word_of("ab"), 8'd0);
    send_item(wft_pkg::KindAdd, word_of("zzzzzzzzzzzzzzzzzzzzzzzz"), 8'd0);
    send_item(wft_pkg::KindAdd, '1, 8'hFF);
    send_item(wft_pkg::KindAdd, word_of("ab") | 120'h1F, 8'd0);
    send_item(wft_pkg::KindAdd, word_of("abcdefghijklmnopqrstuvwx"), 8'd0);
    send_item(wft_pkg::KindAdd, word_of("mango"), 8'd0);
    send_item(wft_pkg::KindAdd, word_of("abc"), 8'd0);
    send_item(wft_pkg::KindRead, '1, 8'd2);
    send_item(wft_pkg::KindRead, '0, 8'd7);
    send_item(wft_pkg::KindRead, '0, 8'd255);
    send_item(wft_pkg::KindRemove, '0, 8'd0);
    send_item(wft_pkg::KindRemove, word_of("ab"), 8'd0);
    send_item(wft_pkg::KindSort, '1, 8'hFF);
    for (int i = 0; i < 7; i++) send_item(wft_pkg::KindRead, '0, 8'(i));
  endtask

  task automatic test_random(input int unsigned n_items, input int unsigned s_idle,
                             input int unsigned r_idle);
    int unsigned r;
    logic [wft_pkg::WordW-1:0] w;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int n = 0; n < n_items; n++) begin
      r = $urandom_range(0, 99);
      if (n == n_items / 2) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        drain();
      end
      if (r < 45) begin
        send_item(wft_pkg::KindAdd, vocab[$urandom_range(0, 47)], 8'($urandom));
      end else if (r < 55) begin
        w = ($urandom_range(0, 2) == 0) ? random_bits()
                                        : random_word($urandom_range(0, 24));
        send_item(wft_pkg::KindAdd, w, 8'($urandom));
      end else if (r < 72) begin
        if (r < 63 && tbl_total > 0) w = tbl_word[$urandom_range(0, tbl_total - 1)];
        else if (r < 68) w = vocab[$urandom_range(0, 47)];
        else w = random_bits();
        send_item(wft_pkg::KindRemove, w, 8'($urandom));
      end else if (r < 98) begin
        send_item(wft_pkg::KindRead, random_bits(),
                  (r < 92) ? 8'($urandom_range(0, tbl_total)) : 8'($urandom));
      end else begin
        send_item(wft_pkg::KindSort, random_bits(), 8'($urandom));
      end
    end
  endtask

  task automatic test_full_table();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (tbl_total < wft_pkg::Capacity)
      send_item(wft_pkg::KindAdd, random_word($urandom_range(1, 24)), 8'd0);
    send_item(wft_pkg::KindAdd, word_of("overflow"), 8'd0);
    send_item(wft_pkg::KindAdd, tbl_word[wft_pkg::Capacity-1], 8'd0);
    send_item(wft_pkg::KindRead, '0, 8'd255);
    send_item(wft_pkg::KindSort, '0, 8'd0);
    send_item(wft_pkg::KindRead, '0, 8'd0);
    send_item(wft_pkg::KindRead, '0, 8'd255);
    send_item(wft_pkg::KindRemove, tbl_word[wft_pkg::Capacity-1], 8'd0);
    send_item(wft_pkg::KindRemove, tbl_word[0], 8'd0);
    send_item(wft_pkg::KindRead, '0, 8'd254);
  endtask

  initial begin
    tbl_total = 0;
    error_count = 0;
    cycle_count = 0;
    send_idle_pct = 18;
    recv_idle_pct = 56;
    for (int i = 0; i < 48; i++) vocab[i] = random_word($urandom_range(0, 24));
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(440, 18, 56);
    test_random(440, 56, 18);
    test_random(420, 0, 0);
    test_full_table();
    s_axis_tvalid <= 1'b0;
    drain();
    repeat (50) @(posedge clk_i);
    if (error_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
